/* src/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared constants, register indexes and status codes for the barometric
// compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int unsigned DivWidth = 32;

    typedef enum logic [1:0] {
        REG_CAL_A = 2'd0,
        REG_CAL_B = 2'd1,
        REG_CAL_C = 2'd2,
        REG_NONE  = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DIVZERO = 2'd1,
        ST_CLAMP   = 2'd2,
        ST_RSVD    = 2'd3
    } t_status;

    localparam logic [31:0] C4000  = 32'd4000;
    localparam logic [31:0] C32768 = 32'd32768;
    localparam logic [31:0] C50000 = 32'd50000;
    localparam logic [31:0] C3038  = 32'd3038;
    localparam logic [31:0] CM7357 = 32'hFFFF_E343;
    localparam logic [31:0] C3791  = 32'd3791;

    // per-stage divider step: one quotient bit
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
    } t_div_state;

    function automatic t_div_state div_step(t_div_state s, logic [31:0] d);
        logic [32:0] trial;
        t_div_state  r;
        trial = {s.rem, s.quo[31]} - {1'b0, d};
        if (!trial[32]) begin
            r.rem = trial[31:0];
            r.quo = {s.quo[30:0], 1'b1};
        end else begin
            r.rem = {s.rem[30:0], s.quo[31]};
            r.quo = {s.quo[30:0], 1'b0};
        end
        return r;
    endfunction

endpackage

/* src/baro_temp_pressure_compensate.sv */
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensate
// Barometer compensation: raw temperature and pressure words in, temperature
// in 0.1 degC and pressure in Pa out, with clamp and divide-by-zero status.
// ----------------------------------------------------------------------------
// Usage: load the three calibration words through the write port while the
// block is idle. Input words (raw_temp, raw_pressure) enter on a valid/ready
// channel; one result word per input leaves on a valid/ready channel with
// temp_tenths, pressure_pa and status.
// Throughput: one word per cycle. The whole pipeline advances together when
// the output register is empty or being taken; a result that waits in the
// output register holds every stage, bubbles included.
// Path: a word passes the multiply stages and two 32-stage dividers
// (temperature divisor X1+MD, then pressure divisor B4) before o_valid rises.
// Reset: clears all valid bits and the calibration words to zero.
// Stall: when the receiver holds ready low with a result pending, the whole
// pipeline freezes and input ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensate
    import bpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [15:0]        i_raw_temp,
    input  logic [15:0]        i_raw_pressure,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_temp_tenths,
    output logic [16:0]        o_pressure_pa,
    output logic [1:0]         o_status
);

    logic [63:0] r_cal_a, r_cal_b;
    logic [31:0] r_cal_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_a <= '0;
            r_cal_b <= '0;
            r_cal_c <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_CAL_A: r_cal_a <= i_cfg_data;
                REG_CAL_B: r_cal_b <= i_cfg_data;
                REG_CAL_C: r_cal_c <= i_cfg_data[31:0];
                default:   ;
            endcase
        end
    end

    function automatic logic [31:0] sx(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = sx(r_cal_a[63:48]);
    assign ac2 = sx(r_cal_a[47:32]);
    assign ac3 = sx(r_cal_a[31:16]);
    assign ac4 = {16'd0, r_cal_a[15:0]};
    assign ac5 = {16'd0, r_cal_b[63:48]};
    assign ac6 = {16'd0, r_cal_b[47:32]};
    assign b1  = sx(r_cal_b[31:16]);
    assign b2  = sx(r_cal_b[15:0]);
    assign mc  = sx(r_cal_c[31:16]);
    assign md  = sx(r_cal_c[15:0]);

    function automatic logic [31:0] asr(logic [31:0] v, int unsigned n);
        return 32'($signed(v) >>> n);
    endfunction

    logic r_out_vld;
    logic en;
    assign en      = !r_out_vld || i_ready;
    assign o_ready = en;

    // ---- stage 1: x1 product
    logic        r1_v;
    logic [31:0] r1_prod;
    logic [15:0] r1_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en) r1_v <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_prod <= ({16'd0, i_raw_temp} - ac6) * ac5;
            r1_up   <= i_raw_pressure;
        end
    end

    // ---- stage 2: x1, divisor, signs
    logic        r2_v;
    logic [31:0] r2_x1, r2_ma, r2_mb;
    logic        r2_neg, r2_dz;
    logic [15:0] r2_up;
    logic [31:0] s2_x1, s2_den, s2_num;
    assign s2_x1  = asr(r1_prod, 15);
    assign s2_den = s2_x1 + md;
    assign s2_num = mc << 11;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (en) r2_v <= r1_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_x1  <= s2_x1;
            r2_ma  <= s2_num[31] ? 32'd0 - s2_num : s2_num;
            r2_mb  <= s2_den[31] ? 32'd0 - s2_den : s2_den;
            r2_neg <= s2_num[31] ^ s2_den[31];
            r2_dz  <= (s2_den == 32'd0);
            r2_up  <= r1_up;
        end
    end

    // ---- temperature divider
    localparam int unsigned S1 = 32 + 16 + 1 + 1;
    logic          d1_v;
    logic [31:0]   d1_q;
    logic [S1-1:0] d1_side;
    bpc_udiv_pipe #(.Side(S1)) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_v),
        .i_num   (r2_ma),
        .i_den   (r2_dz ? 32'd1 : r2_mb),
        .i_side  ({r2_x1, r2_up, r2_neg, r2_dz}),
        .o_valid (d1_v),
        .o_quo   (d1_q),
        .o_side  (d1_side)
    );

    // ---- stage 3: b5, t, b6, square product
    logic        r3_v, r3_dz;
    logic [31:0] r3_t, r3_b6, r3_b6sq;
    logic [15:0] r3_up;
    logic [31:0] s3_x2, s3_b5, s3_b6;
    assign s3_x2 = d1_side[1] ? 32'd0 - d1_q : d1_q;
    assign s3_b5 = d1_side[S1-1 -: 32] + s3_x2;
    assign s3_b6 = s3_b5 - C4000;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en) r3_v <= d1_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_dz   <= d1_side[0];
            r3_t    <= asr(s3_b5 + 32'd8, 4);
            r3_b6   <= s3_b6;
            r3_b6sq <= s3_b6 * s3_b6;
            r3_up   <= d1_side[17:2];
        end
    end

    // ---- stage 4: products on sq and b6
    logic        r4_v, r4_dz;
    logic [31:0] r4_t, r4_p1, r4_p2, r4_p3, r4_p4;
    logic [15:0] r4_up;
    logic [31:0] s4_sq;
    assign s4_sq = asr(r3_b6sq, 12);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (en) r4_v <= r3_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_dz <= r3_dz;
            r4_t  <= r3_t;
            r4_up <= r3_up;
            r4_p1 <= b2 * s4_sq;
            r4_p2 <= ac2 * r3_b6;
            r4_p3 <= ac3 * r3_b6;
            r4_p4 <= b1 * s4_sq;
        end
    end

    // ---- stage 5: b3, x3
    logic        r5_v, r5_dz;
    logic [31:0] r5_t, r5_b3, r5_x3;
    logic [15:0] r5_up;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (en) r5_v <= r4_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_dz <= r4_dz;
            r5_t  <= r4_t;
            r5_up <= r4_up;
            r5_b3 <= asr((ac1 << 2) + asr(r4_p1, 11) + asr(r4_p2, 11) + 32'd2, 2);
            r5_x3 <= asr(asr(r4_p3, 13) + asr(r4_p4, 16) + 32'd2, 2);
        end
    end

    // ---- stage 6: b4 product, b7 product
    logic        r6_v, r6_dz;
    logic [31:0] r6_t, r6_b4p, r6_b7;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else if (en) r6_v <= r5_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_dz  <= r5_dz;
            r6_t   <= r5_t;
            r6_b4p <= ac4 * (r5_x3 + C32768);
            r6_b7  <= ({16'd0, r5_up} - r5_b3) * C50000;
        end
    end

    // ---- stage 7: choose division branch
    logic        r7_v, r7_dz, r7_hi;
    logic [31:0] r7_t, r7_num, r7_b4;
    logic [31:0] s7_b4;
    assign s7_b4 = r6_b4p >> 15;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else if (en) r7_v <= r6_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_dz  <= r6_dz || (s7_b4 == 32'd0);
            r7_t   <= r6_t;
            r7_hi  <= r6_b7[31];
            r7_num <= r6_b7[31] ? r6_b7 : (r6_b7 << 1);
            r7_b4  <= (s7_b4 == 32'd0) ? 32'd1 : s7_b4;
        end
    end

    // ---- pressure divider
    localparam int unsigned S2 = 32 + 2;
    logic          d2_v;
    logic [31:0]   d2_q;
    logic [S2-1:0] d2_side;
    bpc_udiv_pipe #(.Side(S2)) u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r7_v),
        .i_num   (r7_num),
        .i_den   (r7_b4),
        .i_side  ({r7_t, r7_hi, r7_dz}),
        .o_valid (d2_v),
        .o_quo   (d2_q),
        .o_side  (d2_side)
    );

    // ---- stage 8: p, correction products
    logic        r8_v, r8_dz;
    logic [31:0] r8_t, r8_p, r8_sqp, r8_x2p;
    logic [31:0] s8_p, s8_ps;
    assign s8_p  = d2_side[1] ? (d2_q << 1) : d2_q;
    assign s8_ps = asr(s8_p, 8);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r8_v <= 1'b0;
        else if (en) r8_v <= d2_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_dz  <= d2_side[0];
            r8_t   <= d2_side[S2-1 -: 32];
            r8_p   <= s8_p;
            r8_sqp <= s8_ps * s8_ps;
            r8_x2p <= CM7357 * s8_p;
        end
    end

    // ---- stage 9: times 3038
    logic        r9_v, r9_dz;
    logic [31:0] r9_t, r9_p, r9_x1p, r9_x2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r9_v <= 1'b0;
        else if (en) r9_v <= r8_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_dz  <= r8_dz;
            r9_t   <= r8_t;
            r9_p   <= r8_p;
            r9_x1p <= r8_sqp * C3038;
            r9_x2  <= asr(r8_x2p, 16);
        end
    end

    // ---- stage 10: final sum, clamp, output register
    logic [31:0] s10_p;
    assign s10_p = r9_p + asr(asr(r9_x1p, 16) + r9_x2 + C3791, 4);

    logic [15:0] n_temp;
    logic [16:0] n_pres;
    t_status     n_st;
    always_comb begin
        n_st   = ST_OK;
        n_temp = r9_t[15:0];
        n_pres = s10_p[16:0];
        if (r9_t[31] && (r9_t < 32'hFFFF_8000)) begin
            n_temp = 16'h8000;
            n_st   = ST_CLAMP;
        end else if (!r9_t[31] && (r9_t > 32'd32767)) begin
            n_temp = 16'h7FFF;
            n_st   = ST_CLAMP;
        end
        if (s10_p[31]) begin
            n_pres = '0;
            n_st   = ST_CLAMP;
        end else if (s10_p > 32'd131071) begin
            n_pres = '1;
            n_st   = ST_CLAMP;
        end
        if (r9_dz) begin
            n_temp = '0;
            n_pres = '0;
            n_st   = ST_DIVZERO;
        end
    end

    logic [15:0] r_temp;
    logic [16:0] r_pres;
    logic [1:0]  r_st;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= 1'b0;
        else if (en) r_out_vld <= r9_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_temp <= n_temp;
            r_pres <= n_pres;
            r_st   <= n_st;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_temp_tenths = $signed(r_temp);
    assign o_pressure_pa = r_pres;
    assign o_status      = r_st;

endmodule

/* src/bpc_udiv_pipe.sv */
// ----------------------------------------------------------------------------
// bpc_udiv_pipe
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage,
// with a side-band word of Side bits carried alongside. Stalls as a whole.
// ----------------------------------------------------------------------------
module bpc_udiv_pipe
    import bpc_pkg::*;
#(
    parameter int unsigned Side = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [31:0]     i_num,
    input  logic [31:0]     i_den,
    input  logic [Side-1:0] i_side,
    output logic            o_valid,
    output logic [31:0]     o_quo,
    output logic [Side-1:0] o_side
);

    logic [DivWidth-1:0]           r_vld;
    t_div_state [DivWidth-1:0]     r_st;
    logic [DivWidth-1:0][31:0]     r_den;
    logic [DivWidth-1:0][Side-1:0] r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DivWidth-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0]   <= div_step('{rem: 32'd0, quo: i_num}, i_den);
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
            for (int k = 1; k < DivWidth; k++) begin
                r_st[k]   <= div_step(r_st[k-1], r_den[k-1]);
                r_den[k]  <= r_den[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_vld[DivWidth-1];
    assign o_quo   = r_st[DivWidth-1].quo;
    assign o_side  = r_side[DivWidth-1];

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Checks the barometer compensation block against an in-bench predictor of
// the 32-bit compensation arithmetic, over several calibration sets, with
// random idle and stall phases on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import bpc_pkg::*;

    typedef struct {
        logic [15:0] temp;
        logic [16:0] pres;
        logic [1:0]  st;
    } t_reading;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [15:0] i_raw_temp;
    logic [15:0] i_raw_pressure;
    logic        o_valid;
    logic        i_ready;
    logic signed [15:0] o_temp_tenths;
    logic [16:0] o_pressure_pa;
    logic [1:0]  o_status;

    logic [63:0] cal_a, cal_b;
    logic [31:0] cal_c;
    t_reading    expected_q[$];
    int          err_count;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;

    baro_temp_pressure_compensate u_dut (.*);

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic logic [31:0] asr(logic [31:0] v, int n);
        return 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sx(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma, mb, q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic t_reading compensate(logic [15:0] ut16, logic [15:0] up16);
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
        logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, sq, t, p, den;
        t_reading r;
        ac1 = sx(cal_a[63:48]); ac2 = sx(cal_a[47:32]);
        ac3 = sx(cal_a[31:16]); ac4 = {16'd0, cal_a[15:0]};
        ac5 = {16'd0, cal_b[63:48]}; ac6 = {16'd0, cal_b[47:32]};
        b1 = sx(cal_b[31:16]); b2 = sx(cal_b[15:0]);
        mc = sx(cal_c[31:16]); md = sx(cal_c[15:0]);
        ut = {16'd0, ut16}; up = {16'd0, up16};
        r = '{16'd0, 17'd0, ST_DIVZERO};
        x1 = asr((ut - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0) return r;
        x2 = sdiv(mc << 11, den);
        b5 = x1 + x2;
        t = asr(b5 + 32'd8, 4);
        b6 = b5 - C4000;
        sq = asr(b6 * b6, 12);
        x1 = asr(b2 * sq, 11);
        x2 = asr(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = asr(ac1 * 32'd4 + x3 + 32'd2, 2);
        x1 = asr(ac3 * b6, 13);
        x2 = asr(b1 * sq, 16);
        x3 = asr(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + C32768)) >> 15;
        if (b4 == 0) return r;
        b7 = (up - b3) * C50000;
        if (!b7[31]) p = (b7 * 32'd2) / b4;
        else         p = (b7 / b4) * 32'd2;
        x1 = asr(p, 8) * asr(p, 8);
        x1 = asr(x1 * C3038, 16);
        x2 = asr(CM7357 * p, 16);
        p = p + asr(x1 + x2 + C3791, 4);
        r.st = ST_OK;
        if ($signed(t) < -32768) begin
            t = 32'hFFFF_8000; r.st = ST_CLAMP;
        end else if ($signed(t) > 32767) begin
            t = 32'd32767; r.st = ST_CLAMP;
        end
        if (p[31]) begin
            p = 0; r.st = ST_CLAMP;
        end else if (p > 32'd131071) begin
            p = 32'd131071; r.st = ST_CLAMP;
        end
        r.temp = t[15:0];
        r.pres = p[16:0];
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        err_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_reading e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                report("unexpected word", 0, 0);
            end else begin
                e = expected_q.pop_front();
                if (o_temp_tenths !== e.temp) report("temp", o_temp_tenths, e.temp);
                if (o_pressure_pa !== e.pres) report("pressure", o_pressure_pa, e.pres);
                if (o_status !== e.st) report("status", o_status, e.st);
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on accepted words
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // valid stays high after the word is taken; the next idle gap or drain drops it
    task automatic send_word(logic [15:0] ut, logic [15:0] up);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_raw_temp <= ut;
        i_raw_pressure <= up;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_q.push_back(compensate(ut, up));
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    // write enable stays high; the caller drops it after the last write
    task automatic write_cal(t_reg_idx idx, logic [63:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= d;
        case (idx)
            REG_CAL_A: cal_a = d;
            REG_CAL_B: cal_b = d;
            REG_CAL_C: cal_c = d[31:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic load_cal(logic [63:0] a, logic [63:0] b, logic [31:0] c);
        drain();
        write_cal(REG_CAL_A, a);
        write_cal(REG_CAL_B, b);
        write_cal(REG_CAL_C, {32'd0, c});
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // datasheet-like calibration set
    task automatic test_typical();
        load_cal({16'd408, -16'sd72, -16'sd14383, 16'd32741},
                 {16'd32757, 16'd23153, 16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
        send_word(16'd27898, 16'd23843);
        send_word(16'd0, 16'd0);
        send_word(16'hFFFF, 16'hFFFF);
        send_word(16'd0, 16'hFFFF);
        send_word(16'hFFFF, 16'd0);
        send_word(16'd23153, 16'd30000);
    endtask

    task automatic test_corners();
        // all zero: temperature divisor zero
        load_cal(64'd0, 64'd0, 32'd0);
        send_word(16'd1234, 16'd4321);
        // AC4 zero: pressure divisor zero
        load_cal(64'd0, 64'd0, 32'h0000_0001);
        send_word(16'd100, 16'd200);
        // MC=-32768, divisor -1 path and large temperature clamp
        load_cal(64'h0000_0000_0000_FFFF, 64'h0001_0000_0000_0000, 32'h8000_FFFF);
        send_word(16'd0, 16'd0);
        send_word(16'd1, 16'hFFFF);
        // all ones everywhere
        load_cal({64{1'b1}}, {64{1'b1}}, 32'hFFFF_FFFF);
        send_word(16'hFFFF, 16'hFFFF);
        send_word(16'h0000, 16'h8000);
        // extremes of sign bits
        load_cal(64'h8000_7FFF_8000_FFFF, 64'hFFFF_FFFF_7FFF_8000, 32'h7FFF_8000);
        send_word(16'h8000, 16'h7FFF);
        send_word(16'h7FFF, 16'h8000);
        // ignored index
        drain();
        write_cal(REG_NONE, rnd64());
        i_cfg_we <= 1'b0;
        send_word(16'h5555, 16'hAAAA);
    endtask

    task automatic run_random(int n);
        repeat (n) send_word($urandom, $urandom);
    endtask

    task automatic test_random();
        int ph;
        for (ph = 0; ph < 8; ph++) begin
            if (ph % 2 == 0)
                load_cal({16'($urandom_range(0, 800)), 16'($signed($urandom_range(0, 400)) - 200),
                          16'(-$urandom_range(10000, 16000)), 16'($urandom_range(30000, 40000))},
                         {16'($urandom_range(20000, 40000)), 16'($urandom_range(15000, 30000)),
                          16'($urandom_range(5000, 8000)), 16'($urandom_range(0, 100))},
                         {16'(-$urandom_range(8000, 12000)), 16'($urandom_range(2000, 3000))});
            else
                load_cal(rnd64(), rnd64(), $urandom);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            run_random(140);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    // hold the receiver off so the pipeline fills and stalls the input
    task automatic test_backpressure();
        int i;
        fork
            run_random(150);
            begin
                hold_off = 1'b1;
                for (i = 0; i < 400; i++) @(negedge i_clk);
                hold_off = 1'b0;
            end
        join
        drain();
        run_random(20);
    endtask

    initial begin
        err_count = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cal_a = 0; cal_b = 0; cal_c = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_CAL_A;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_raw_temp = '0;
        i_raw_pressure = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_typical();
        test_corners();
        test_random();
        test_backpressure();
        drain();
        if (err_count == 0) $display("tb_top: clean");
        else $display("tb_top: errors");
        $finish;
    end
endmodule
